// ===== hdl/tpre_pkg.sv =====
// Shared types and constants of the touch point report engine.
package tpre_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MAX_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MAX_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd6;

  localparam logic [1:0] EV_CONTACT = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_SYNC    = 2'd2;

  localparam logic [7:0] NO_POINT      = 8'hFF;
  localparam logic [7:0] STATUS_DOWN   = 8'h01;
  localparam logic [7:0] STATUS_MOVE   = 8'h02;
  localparam logic [11:0] COORD_MAX    = 12'hFFF;
  localparam logic [3:0] SCALE_DEFAULT = 4'h1;

  typedef struct packed {
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
    logic [7:0] point_status;
    logic [7:0] touch_id;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        last_event;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] kind;
    logic       last;
    logic       mark;
    logic       step;
    logic       frame_update;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic rec_valid;
    logic rec_fend;
    logic rel_bit;
    logic scan_last;
    logic reported;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POINT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SYNC  = 4'b1000
  } state_t;

endpackage

// ===== hdl/touch_point_report_engine.sv =====
// Top level of the touch point report engine.
//
// One request on the input channel carries one point record of a touch
// frame; frame_end marks the last record of the frame. Each valid record
// gives a contact result on the output channel. The record with frame_end
// then gives a release result for each slot that was pressed in the
// previous frame and not in this one, in ascending slot order, followed by
// a sync result if the frame reported anything. last_event marks the final
// result of a record. Configuration writes are taken at any clock edge with
// cfg_we high; the user must write only while no record is in flight; the
// block does not enforce it. For a record without frame_end, the record is
// registered, then the contact enters the output register once it is free
// and in_ready returns then. A record with frame_end then runs the release
// scan, one slot per cycle unless a release waits for a busy output register,
// and ends with the sync step. A stalled receiver holds the engine in place
// whenever it has a new result ready, dropping none. Reset restores the
// register defaults and clears the slot masks, out_valid and state machine.
module touch_point_report_engine
  import tpre_pkg::*;
#(
  parameter int unsigned SLOTS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  cmd_t cmd;
  sts_t sts;

  tpre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpre_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/tpre_ctrl.sv =====
// Sequencing state machine of the touch point report engine.
module tpre_ctrl
  import tpre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_POINT;
        end
      end
      S_POINT: begin
        if (sts.rec_valid) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = EV_CONTACT;
            cmd.last  = !sts.rec_fend;
            cmd.mark  = 1'b1;
            state_nxt = sts.rec_fend ? S_SCAN : S_IDLE;
          end
        end else begin
          state_nxt = sts.rec_fend ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.rel_bit || sts.out_free) begin
          cmd.emit = sts.rel_bit;
          cmd.kind = EV_RELEASE;
          cmd.step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_SYNC;
          end
        end
      end
      S_SYNC: begin
        if (!sts.reported || sts.out_free) begin
          cmd.emit         = sts.reported;
          cmd.kind         = EV_SYNC;
          cmd.last         = 1'b1;
          cmd.frame_update = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tpre_datapath.sv =====
// Record decode, coordinate transform, slot masks and result register.
module tpre_datapath
  import tpre_pkg::*;
#(
  parameter int unsigned SLOTS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_t                   in_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  localparam int unsigned SCNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [11:0] screen_max_x_r;
  logic [11:0] screen_max_y_r;
  logic        swap_axes_r;
  logic        mirror_x_r;
  logic        mirror_y_r;
  logic [3:0]  scale_x_r;
  logic [3:0]  scale_y_r;

  in_t               rec_r;
  logic [SLOTS-1:0]  pressed_now_r;
  logic [SLOTS-1:0]  pressed_now_nxt;
  logic [SLOTS-1:0]  pressed_before_r;
  logic              reported_r;
  logic [SCNT_W-1:0] scan_r;
  logic              out_valid_r;
  out_t              out_data_r;
  out_t              out_data_nxt;

  logic [11:0] raw_x;
  logic [11:0] raw_y;
  logic [11:0] sw_x;
  logic [11:0] sw_y;
  logic [11:0] mir_x;
  logic [11:0] mir_y;
  logic [3:0]  contact_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_max_x_r <= COORD_MAX;
      screen_max_y_r <= COORD_MAX;
      swap_axes_r    <= 1'b0;
      mirror_x_r     <= 1'b0;
      mirror_y_r     <= 1'b0;
      scale_x_r      <= SCALE_DEFAULT;
      scale_y_r      <= SCALE_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_MAX_X: screen_max_x_r <= cfg_wdata;
        REG_SCREEN_MAX_Y: screen_max_y_r <= cfg_wdata;
        REG_SWAP_AXES:    swap_axes_r    <= cfg_wdata[0];
        REG_MIRROR_X:     mirror_x_r     <= cfg_wdata[0];
        REG_MIRROR_Y:     mirror_y_r     <= cfg_wdata[0];
        REG_SCALE_X:      scale_x_r      <= cfg_wdata[3:0];
        REG_SCALE_Y:      scale_y_r      <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  assign raw_x = {rec_r.x_high, rec_r.x_low[3:0]};
  assign raw_y = {rec_r.y_high, rec_r.y_low[3:0]};
  assign sw_x  = swap_axes_r ? raw_y : raw_x;
  assign sw_y  = swap_axes_r ? raw_x : raw_y;

  always_comb begin
    mir_x = sw_x;
    mir_y = sw_y;
    if (mirror_x_r) begin
      mir_x = (sw_x > screen_max_x_r) ? 12'd0 : (screen_max_x_r - sw_x);
    end
    if (mirror_y_r) begin
      mir_y = (sw_y > screen_max_y_r) ? 12'd0 : (screen_max_y_r - sw_y);
    end
  end

  assign contact_slot = 4'(rec_r.touch_id - 8'd1);

  always_comb begin
    sts.out_free  = !out_valid_r || out_ready;
    sts.rec_valid = (rec_r.x_high != NO_POINT) && (rec_r.y_high != NO_POINT) &&
                    ((rec_r.point_status == STATUS_DOWN) ||
                     (rec_r.point_status == STATUS_MOVE)) &&
                    (rec_r.touch_id != 8'd0) && (rec_r.touch_id <= 8'(SLOTS));
    sts.rec_fend  = rec_r.frame_end;
    sts.rel_bit   = pressed_before_r[scan_r] && !pressed_now_r[scan_r];
    sts.scan_last = (scan_r == SCNT_W'(SLOTS - 1));
    sts.reported  = reported_r;
  end

  always_comb begin
    pressed_now_nxt = pressed_now_r;
    for (int i = 0; i < SLOTS; i++) begin
      if (contact_slot == 4'(i)) begin
        pressed_now_nxt[i] = 1'b1;
      end
    end
  end

  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.event_kind = cmd.kind;
    out_data_nxt.last_event = cmd.last;
    case (cmd.kind)
      EV_CONTACT: begin
        out_data_nxt.slot  = contact_slot;
        out_data_nxt.pos_x = 16'(mir_x) * 16'(scale_x_r);
        out_data_nxt.pos_y = 16'(mir_y) * 16'(scale_y_r);
      end
      EV_RELEASE: begin
        out_data_nxt.slot = 4'(scan_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_r <= in_data;
    end
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_now_r    <= '0;
      pressed_before_r <= '0;
      reported_r       <= 1'b0;
      scan_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.mark) begin
        pressed_now_r <= pressed_now_nxt;
      end
      if (cmd.mark || (cmd.emit && (cmd.kind == EV_RELEASE))) begin
        reported_r <= 1'b1;
      end
      if (cmd.step && !sts.scan_last) begin
        scan_r <= scan_r + SCNT_W'(1);
      end
      if (cmd.frame_update) begin
        pressed_before_r <= pressed_now_r;
        pressed_now_r    <= '0;
        reported_r       <= 1'b0;
        scan_r           <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
